// File: rtl/arat_pkg.sv
`timescale 1ns / 1ps
// Package for the address range table allocator.
// Holds default parameters, field widths, operation and status codes.
package arat_pkg;

	localparam int DEF_MAX_RANGES = 32;
	localparam int DEF_PAGE_BITS  = 12;
	localparam int DEF_ADDR_BITS  = 48;

	localparam int OP_W    = 2;
	localparam int FIELD_W = 48;
	localparam int RANK_W  = 5;
	localparam int STAT_W  = 3;
	localparam int CNT_W   = 6;

	localparam int IN_BITS  = OP_W + 2 * FIELD_W + RANK_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = STAT_W + 2 * FIELD_W + CNT_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [OP_W-1:0] OP_LOCATE = 2'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
	localparam logic [OP_W-1:0] OP_ALLOC  = 2'd2;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd1;
	localparam logic [STAT_W-1:0] ST_NO_SPACE  = 3'd2;
	localparam logic [STAT_W-1:0] ST_INVALID   = 3'd3;
	localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

endpackage

// File: rtl/address_range_table_allocator.sv
`timescale 1ns / 1ps
// Address range table allocator: sorted range table in one RAM, walked one entry a cycle.
// Locate and remove make one scan of the table; insert and alloc scan, then shift the
// entries from the insert position up by one while writing the new range in, a single
// write when it lands past the last entry. A stalled output holds the block in S_DONE.
// One word in flight at a time; the RAM read port sets the one-entry-a-cycle pace.
// Reset (arst_n low) clears the range count and control; the RAM is not cleared.
module address_range_table_allocator #(
	parameter int MAX_RANGES = arat_pkg::DEF_MAX_RANGES,
	parameter int PAGE_BITS  = arat_pkg::DEF_PAGE_BITS,
	parameter int ADDR_BITS  = arat_pkg::DEF_ADDR_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// operation[1:0], addr[49:2], limit[97:50], rank[102:98], zero fill
	input  logic [arat_pkg::IN_W-1:0]  s_axis_tdata,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// status[2:0], range_start[50:3], range_stop[98:51], range_count[104:99], zero fill
	output logic [arat_pkg::OUT_W-1:0] m_axis_tdata
);
	import arat_pkg::*;

	localparam int AW = ADDR_BITS;
	localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int CW = $clog2(MAX_RANGES + 1);

	localparam logic [AW-1:0] PM        = {{(AW-PAGE_BITS){1'b0}}, {PAGE_BITS{1'b1}}};
	localparam logic [AW-1:0] PAGE      = PM + 1'b1;
	localparam logic [AW-1:0] MASK      = '1;
	localparam logic [AW-1:0] MASK_PM   = MASK - PM;
	localparam logic [AW-1:0] MASK_PAGE = MASK - PAGE;
	localparam logic [CW-1:0] FULL_CNT  = CW'(MAX_RANGES);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FILL = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	// input field split
	logic [OP_W-1:0]    in_op;
	logic [FIELD_W-1:0] in_addr_f, in_limit_f;
	logic [RANK_W-1:0]  in_rank;
	logic [AW-1:0]      in_a, in_e;
	assign in_op      = s_axis_tdata[OP_W-1:0];
	assign in_addr_f  = s_axis_tdata[OP_W +: FIELD_W];
	assign in_limit_f = s_axis_tdata[OP_W+FIELD_W +: FIELD_W];
	assign in_rank    = s_axis_tdata[OP_W+2*FIELD_W +: RANK_W];
	assign in_a       = AW'(in_addr_f);
	assign in_e       = AW'(in_limit_f);

	// registers
	logic [1:0]        state_q;
	logic [OP_W-1:0]   op_q;
	logic [AW-1:0]     a_q, e_q, size_q, msz_q, cand_q, cend_q;
	logic [AW-1:0]     res_s_q, res_e_q;
	logic [STAT_W-1:0] stat_q;
	logic [CW-1:0]     used_q, r_q, pos_q;
	logic              stop_q, hit_q, fail_q, ovl_q;
	logic              rv_s1;
	logic [IW-1:0]     ri_s1;
	logic [OUT_W-1:0]  out_q;
	logic              out_v_q;

	// RAM port signals
	logic              rd_issue, we;
	logic [IW-1:0]     waddr;
	logic [2*AW-1:0]   wdata, rdata;
	logic [AW-1:0]     ds, de;
	assign ds = rdata[AW-1:0];
	assign de = rdata[2*AW-1:AW];

	arat_ram #(.DATA_W(2 * AW), .DEPTH(MAX_RANGES), .ADR_W(IW)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (r_q[IW-1:0]),
		.rdata (rdata)
	);

	// alloc size and first candidate at accept
	logic [6:0]    shamt;
	logic          size_ok, cand_ok;
	logic [AW-1:0] size_c, cand0;
	assign shamt   = 7'(PAGE_BITS) + 7'(in_rank);
	assign size_ok = shamt < 7'(ADDR_BITS);
	assign size_c  = size_ok ? (AW'(1) << shamt) : '0;
	assign cand0   = (in_a + PM) & ~PM;
	assign cand_ok = (in_a <= MASK_PM) && size_ok && (cand0 <= MASK - size_c);

	// guard bounds of the entry being walked
	logic [AW-1:0] gsb, gs, gep, ge;
	assign gsb = ds & ~PM;
	assign gs  = (gsb >= PAGE) ? gsb - PAGE : '0;
	assign gep = (de + PM) & ~PM;
	assign ge  = gep + PAGE;

	logic scan_end, done_go, accept;
	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign scan_end      = (state_q == S_SCAN) && !rv_s1 && (stop_q || r_q >= used_q);
	assign done_go       = (state_q == S_DONE) && (!out_v_q || m_axis_tready);

	// RAM read issue and write select
	always_comb begin
		rd_issue = ((state_q == S_SCAN) && !stop_q && (r_q < used_q)) ||
		           ((state_q == S_FILL) && (r_q < used_q));
		we    = 1'b0;
		waddr = ri_s1;
		wdata = rdata;
		if (state_q == S_SCAN && rv_s1 && op_q == OP_REMOVE && hit_q) begin
			we    = 1'b1;
			waddr = ri_s1 - 1'b1;
		end else if (state_q == S_FILL) begin
			wdata = {cend_q, cand_q};
			if (rv_s1) begin
				we = 1'b1;
			end else if (r_q == used_q) begin
				we    = 1'b1;
				waddr = used_q[IW-1:0];
			end
		end
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q  <= '0;
			r_q     <= '0;
			rv_s1   <= 1'b0;
			stop_q  <= 1'b0;
			hit_q   <= 1'b0;
			fail_q  <= 1'b0;
			ovl_q   <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			rv_s1 <= rd_issue;
			if (rd_issue) begin
				r_q <= r_q + 1'b1;
			end
			// present a new word, or drop the one taken
			if (done_go) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						r_q    <= '0;
						stop_q <= 1'b0;
						hit_q  <= 1'b0;
						fail_q <= 1'b0;
						ovl_q  <= 1'b0;
						unique case (in_op)
							OP_INSERT: begin
								if ((in_a & PM) != '0 || in_a >= in_e) begin
									stat_q  <= ST_INVALID;
									state_q <= S_DONE;
								end else begin
									state_q <= S_SCAN;
								end
							end
							OP_ALLOC: begin
								if (in_a >= in_e) begin
									stat_q  <= ST_INVALID;
									state_q <= S_DONE;
								end else if (used_q == FULL_CNT) begin
									stat_q  <= ST_FULL;
									state_q <= S_DONE;
								end else if (!cand_ok) begin
									stat_q  <= ST_NO_SPACE;
									state_q <= S_DONE;
								end else begin
									state_q <= S_SCAN;
								end
							end
							default: state_q <= S_SCAN;
						endcase
					end
				end
				S_SCAN: begin
					if (rv_s1 && !stop_q) begin
						case (op_q)
							OP_LOCATE: begin
								if (ds <= a_q && a_q < de) begin
									hit_q  <= 1'b1;
									stop_q <= 1'b1;
								end
							end
							OP_INSERT: begin
								if (ds < e_q && a_q < de) begin
									ovl_q <= 1'b1;
								end
							end
							OP_REMOVE: begin
								if (!hit_q && ds == a_q) begin
									hit_q <= 1'b1;
								end
							end
							default: begin
								if (cend_q <= gs) begin
									stop_q <= 1'b1;
								end else if (de > MASK_PM || gep > MASK_PAGE) begin
									fail_q <= 1'b1;
									stop_q <= 1'b1;
								end else if (ge > cand_q && ge > msz_q) begin
									fail_q <= 1'b1;
									stop_q <= 1'b1;
								end
							end
						endcase
					end
					if (scan_end) begin
						case (op_q)
							OP_LOCATE: begin
								stat_q  <= hit_q ? ST_OK : ST_NOT_FOUND;
								state_q <= S_DONE;
							end
							OP_REMOVE: begin
								stat_q  <= hit_q ? ST_OK : ST_NOT_FOUND;
								state_q <= S_DONE;
								if (hit_q) begin
									used_q <= used_q - 1'b1;
								end
							end
							OP_INSERT: begin
								if (ovl_q) begin
									stat_q  <= ST_INVALID;
									state_q <= S_DONE;
								end else if (used_q == FULL_CNT) begin
									stat_q  <= ST_FULL;
									state_q <= S_DONE;
								end else begin
									stat_q  <= ST_OK;
									r_q     <= pos_q;
									state_q <= S_FILL;
								end
							end
							default: begin
								if (fail_q || cend_q > e_q) begin
									stat_q  <= ST_NO_SPACE;
									state_q <= S_DONE;
								end else begin
									stat_q  <= ST_OK;
									r_q     <= pos_q;
									state_q <= S_FILL;
								end
							end
						endcase
					end
				end
				S_FILL: begin
					if (!rv_s1 && r_q == used_q) begin
						used_q  <= used_q + 1'b1;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (done_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	logic [63:0] rs_w, re_w;
	assign rs_w = 64'(res_s_q);
	assign re_w = 64'(res_e_q);

	always_ff @(posedge clk) begin
		ri_s1 <= r_q[IW-1:0];
		// latch the word and prime the walk
		if (accept) begin
			op_q    <= in_op;
			a_q     <= in_a;
			e_q     <= in_e;
			pos_q   <= '0;
			size_q  <= size_c;
			msz_q   <= MASK - size_c;
			res_s_q <= '0;
			res_e_q <= '0;
			if (in_op == OP_ALLOC) begin
				cand_q <= cand0;
				cend_q <= cand0 + size_c;
			end else begin
				cand_q <= in_a;
				cend_q <= in_e;
			end
		end
		// walk one entry
		if (state_q == S_SCAN && rv_s1 && !stop_q) begin
			case (op_q)
				OP_LOCATE: begin
					if (ds <= a_q && a_q < de) begin
						res_s_q <= ds;
						res_e_q <= de;
					end
				end
				OP_INSERT: begin
					if (ds <= a_q) begin
						pos_q <= CW'(ri_s1) + 1'b1;
					end
				end
				OP_REMOVE: begin
					if (!hit_q && ds == a_q) begin
						res_s_q <= ds;
						res_e_q <= de;
					end
				end
				default: begin
					if (!(cend_q <= gs) && !(de > MASK_PM || gep > MASK_PAGE)) begin
						pos_q <= CW'(ri_s1) + 1'b1;
						if (ge > cand_q && !(ge > msz_q)) begin
							cand_q <= ge;
							cend_q <= ge + size_q;
						end
					end
				end
			endcase
		end
		// hold the new range as the result before the shift
		if (scan_end && (op_q == OP_INSERT || op_q == OP_ALLOC)) begin
			res_s_q <= cand_q;
			res_e_q <= cend_q;
		end
		// carry displaced entries up during the fill
		if (state_q == S_FILL && rv_s1) begin
			cand_q <= ds;
			cend_q <= de;
		end
		// load the output word
		if (done_go) begin
			out_q <= OUT_W'({CNT_W'(used_q),
				(stat_q == ST_OK) ? re_w[FIELD_W-1:0] : {FIELD_W{1'b0}},
				(stat_q == ST_OK) ? rs_w[FIELD_W-1:0] : {FIELD_W{1'b0}},
				stat_q});
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_q;
endmodule

// File: rtl/arat_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module arat_ram #(
	parameter int DATA_W = 96,
	parameter int DEPTH  = 32,
	parameter int ADR_W  = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADR_W-1:0]  waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADR_W-1:0]  raddr,
	output logic [DATA_W-1:0] rdata
);
	logic [DATA_W-1:0] mem_q [DEPTH];

	// write one word, read one word a cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the address range table allocator: directed and random
// locate/insert/alloc/remove words, checked against an in-bench table predictor.
// Depends on arat_pkg and address_range_table_allocator.
module tb_top;
	import arat_pkg::*;

	localparam int TABLE_DEPTH = DEF_MAX_RANGES;
	localparam longint unsigned ADDR_MASK = (64'd1 << DEF_ADDR_BITS) - 64'd1;
	localparam longint unsigned PAGE      = 64'd1 << DEF_PAGE_BITS;
	localparam longint unsigned PAGE_MASK = PAGE - 64'd1;
	localparam int RANDOM_ITEMS = 1200;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [FIELD_W-1:0] range_start;
		logic [FIELD_W-1:0] range_stop;
		logic [CNT_W-1:0]   range_count;
	} range_result_t;

	// Range table mirror and queue of pending expected results
	class range_scoreboard;
		longint unsigned start_tab[TABLE_DEPTH];
		longint unsigned stop_tab[TABLE_DEPTH];
		int              held;
		range_result_t   pending[$];
		int              mismatches;

		function new();
			held = 0;
			mismatches = 0;
		endfunction

		function bit round_page(input longint unsigned a, output longint unsigned r);
			if (a > ADDR_MASK - PAGE_MASK) return 0;
			r = (a + PAGE_MASK) & ~PAGE_MASK;
			return 1;
		endfunction

		function void place(input longint unsigned s, input longint unsigned e);
			int pos;
			pos = 0;
			while (pos < held && start_tab[pos] <= s) pos++;
			for (int k = held; k > pos; k--) begin
				start_tab[k] = start_tab[k-1];
				stop_tab[k]  = stop_tab[k-1];
			end
			start_tab[pos] = s;
			stop_tab[pos]  = e;
			held++;
		endfunction

		function logic [STAT_W-1:0] insert_range(input longint unsigned s,
				input longint unsigned e);
			if ((s & PAGE_MASK) != 0 || s >= e) return ST_INVALID;
			for (int k = 0; k < held; k++)
				if (start_tab[k] < e && s < stop_tab[k]) return ST_INVALID;
			if (held >= TABLE_DEPTH) return ST_FULL;
			place(s, e);
			return ST_OK;
		endfunction

		function logic [STAT_W-1:0] alloc_range(input longint unsigned zs,
				input longint unsigned ze, input int rank,
				output longint unsigned os, output longint unsigned oe);
			longint unsigned size, cand, cand_end, gs, ge;
			size = PAGE << rank;
			if (zs >= ze) return ST_INVALID;
			if (held >= TABLE_DEPTH) return ST_FULL;
			if (!round_page(zs, cand) || size > ADDR_MASK || cand > ADDR_MASK - size)
				return ST_NO_SPACE;
			cand_end = cand + size;
			for (int k = 0; k < held; k++) begin
				gs = start_tab[k] & ~PAGE_MASK;
				gs = (gs >= PAGE) ? gs - PAGE : 64'd0;
				if (cand_end <= gs) break;
				if (!round_page(stop_tab[k], ge) || ge > ADDR_MASK - PAGE)
					return ST_NO_SPACE;
				ge += PAGE;
				if (ge > cand) begin
					cand = ge;
					if (cand > ADDR_MASK - size) return ST_NO_SPACE;
					cand_end = cand + size;
				end
			end
			if (cand_end > ze) return ST_NO_SPACE;
			place(cand, cand_end);
			os = cand;
			oe = cand_end;
			return ST_OK;
		endfunction

		// Predict the result of one accepted word
		function void note_input(input logic [IN_W-1:0] w);
			logic [OP_W-1:0] op;
			longint unsigned a, lim, rs, re;
			int rank;
			logic [STAT_W-1:0] st;
			range_result_t r;
			op   = w[1:0];
			a    = 64'(w[49:2]) & ADDR_MASK;
			lim  = 64'(w[97:50]) & ADDR_MASK;
			rank = int'(w[102:98]);
			rs = 0;
			re = 0;
			st = ST_NOT_FOUND;
			case (op)
				OP_LOCATE: begin
					for (int k = 0; k < held; k++)
						if (start_tab[k] <= a && a < stop_tab[k]) begin
							st = ST_OK;
							rs = start_tab[k];
							re = stop_tab[k];
							break;
						end
				end
				OP_INSERT: begin
					st = insert_range(a, lim);
					rs = a;
					re = lim;
				end
				OP_ALLOC: begin
					st = alloc_range(a, lim, rank, rs, re);
				end
				default: begin
					for (int k = 0; k < held; k++)
						if (start_tab[k] == a) begin
							st = ST_OK;
							rs = start_tab[k];
							re = stop_tab[k];
							for (int j = k; j + 1 < held; j++) begin
								start_tab[j] = start_tab[j+1];
								stop_tab[j]  = stop_tab[j+1];
							end
							held--;
							break;
						end
				end
			endcase
			if (st != ST_OK) begin
				rs = 0;
				re = 0;
			end
			r.status      = st;
			r.range_start = rs[FIELD_W-1:0];
			r.range_stop  = re[FIELD_W-1:0];
			r.range_count = CNT_W'(held);
			pending.push_back(r);
		endfunction

		// Compare one output word with the oldest prediction
		function void check_result(input logic [OUT_W-1:0] w);
			range_result_t got, want;
			got.status      = w[2:0];
			got.range_start = w[50:3];
			got.range_stop  = w[98:51];
			got.range_count = w[104:99];
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word st=%0d start=%h stop=%h cnt=%0d",
						got.status, got.range_start, got.range_stop, got.range_count);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch exp st=%0d start=%h stop=%h cnt=%0d",
						" / got st=%0d start=%h stop=%h cnt=%0d"},
						want.status, want.range_start, want.range_stop, want.range_count,
						got.status, got.range_start, got.range_stop, got.range_count);
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;

	range_scoreboard sb;
	bit              idle_on;
	int              cycle_cnt = 0;

	address_range_table_allocator u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	// Clock, 12 ns period
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Count cycles and check every accepted output word
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	// Stall the output side at random, with a quiet stretch
	always @(negedge clk) begin
		if (cycle_cnt > 20000 && cycle_cnt < 35000)
			m_axis_tready = 1'b1;
		else
			m_axis_tready = ($urandom_range(99) >= 30);
	end

	task automatic send_word(input logic [OP_W-1:0] op, input logic [FIELD_W-1:0] a,
			input logic [FIELD_W-1:0] lim, input logic [RANK_W-1:0] rank);
		while (idle_on && $urandom_range(99) < 30) @(negedge clk);
		s_axis_tdata  = IN_W'({rank, lim, a, op});
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(s_axis_tdata);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	// Page-aligned address inside a small window so ranges collide often
	function automatic logic [FIELD_W-1:0] near_page();
		return FIELD_W'(64'($urandom_range(511)) << DEF_PAGE_BITS);
	endfunction

	function automatic logic [FIELD_W-1:0] wide_addr();
		return FIELD_W'({$urandom(), $urandom()});
	endfunction

	task automatic send_random();
		logic [OP_W-1:0]    op;
		logic [FIELD_W-1:0] a, lim, base;
		logic [RANK_W-1:0]  rank;
		int                 pick;
		pick = $urandom_range(99);
		if (sb.held >= 28 && pick < 50) op = OP_REMOVE;
		else op = OP_W'($urandom_range(3));
		base = ($urandom_range(99) < 8) ? 48'hFFFF_FFE0_0000 : 48'h0;
		a    = base | near_page();
		if ($urandom_range(99) < 10) a = a | FIELD_W'($urandom_range(4095));
		if ($urandom_range(99) < 4) a = wide_addr();
		lim  = a + FIELD_W'(64'($urandom_range(1, 16)) << DEF_PAGE_BITS);
		if ($urandom_range(99) < 6) lim = wide_addr();
		if ($urandom_range(99) < 3) lim = a;
		rank = ($urandom_range(99) < 8) ? RANK_W'($urandom_range(16, 24))
			: RANK_W'($urandom_range(3));
		case (op)
			OP_ALLOC: begin
				lim = a + FIELD_W'(64'($urandom_range(1, 1024)) << DEF_PAGE_BITS);
				if ($urandom_range(99) < 10) lim = wide_addr();
				if ($urandom_range(99) < 4) lim = a;
			end
			OP_LOCATE, OP_REMOVE: begin
				if (sb.held > 0 && $urandom_range(99) < 70)
					a = FIELD_W'(sb.start_tab[$urandom_range(sb.held - 1)]) +
						((op == OP_LOCATE) ? FIELD_W'($urandom_range(8191)) : 48'h0);
			end
			default: ;
		endcase
		send_word(op, a, lim, rank);
	endtask

	initial begin
		sb = new();
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		idle_on       = 1'b1;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: every operation and each corner case
		send_word(OP_LOCATE, 48'h0, 48'h0, 5'd0);                       // locate on empty table
		send_word(OP_INSERT, 48'h0, 48'h1000, 5'd0);                    // range at address zero
		send_word(OP_INSERT, 48'h1001, 48'h3000, 5'd0);                 // misaligned start
		send_word(OP_INSERT, 48'h5000, 48'h5000, 5'd0);                 // empty range
		send_word(OP_INSERT, 48'h10000, 48'h12001, 5'd0);
		send_word(OP_INSERT, 48'h11000, 48'h13000, 5'd0);               // overlap
		send_word(OP_LOCATE, 48'h12000, 48'h0, 5'd0);                   // hit
		send_word(OP_LOCATE, 48'h20000, 48'h0, 5'd0);                   // miss
		send_word(OP_ALLOC, 48'h0, 48'h100000, 5'd0);                   // guard clipped at zero
		send_word(OP_ALLOC, 48'h20001, 48'h100000, 5'd2);               // zone past held ranges
		send_word(OP_ALLOC, 48'h30000, 48'h30000, 5'd0);                // empty zone
		send_word(OP_ALLOC, 48'h0, 48'h4000, 5'd1);                     // no room in zone
		send_word(OP_ALLOC, 48'hFFFF_FFFF_F001, 48'hFFFF_FFFF_FFFF, 5'd0); // round overflow
		send_word(OP_ALLOC, 48'hFFFF_F000_0000, 48'hFFFF_FFFF_FFFF, 5'd24);
		send_word(OP_ALLOC, 48'hFFFF_FFFF_E000, 48'hFFFF_FFFF_FFFF, 5'd31); // size overflow
		send_word(OP_INSERT, 48'hFFFF_FFFF_F000, 48'hFFFF_FFFF_FFFF, 5'd0);
		send_word(OP_LOCATE, 48'hFFFF_FFFF_FFFE, 48'h0, 5'd0);
		send_word(OP_ALLOC, 48'hFFFF_FF00_0000, 48'hFFFF_FFFF_FFFF, 5'd0); // guard past top
		send_word(OP_REMOVE, 48'h10000, 48'h0, 5'd0);                   // remove hit
		send_word(OP_REMOVE, 48'h10000, 48'h0, 5'd0);                   // remove miss
		send_word(OP_REMOVE, 48'hFFFF_FFFF_F000, 48'h0, 5'd0);

		// Random mix, with a stretch of back-to-back words
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			idle_on = !(i >= 400 && i < 600);
			send_random();
		end

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
		if (sb.mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog
	initial begin
		#30ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule

// File: sim.f
rtl/arat_pkg.sv
rtl/arat_ram.sv
rtl/address_range_table_allocator.sv
sim/tb_top.sv
